/* src/gmsp_pkg.sv */
package gmsp_pkg;

  localparam int GRID_SIDE_DEF = 16;
  localparam int COORD_W       = 4;
  localparam int LEN_W         = 9;
  localparam int LEN_MAX       = 511;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CS_OPEN = 2'd0,
    CS_WALL = 2'd1,
    CS_PATH = 2'd2
  } cell_state_t;

  // probe order: down, right, up, left
  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef struct packed {
    logic              found;
    logic [LEN_W-1:0]  path_length;
    cell_state_t       cell_state;
  } gmsp_res_t;

endpackage

/* src/gmsp_ram.sv */
module gmsp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gmsp_nbr.sv */
module gmsp_nbr
  import gmsp_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic [$clog2(GRID_SIDE)-1:0]             row,
  input  logic [$clog2(GRID_SIDE)-1:0]             col,
  input  dir_t                                     dir,
  output logic                                     valid,
  output logic [$clog2(GRID_SIDE)-1:0]             nrow,
  output logic [$clog2(GRID_SIDE)-1:0]             ncol,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   nidx
);

  localparam int RCW = $clog2(GRID_SIDE);
  localparam int CW  = $clog2(GRID_SIDE * GRID_SIDE);

  always_comb begin
    valid = 1'b0;
    nrow  = row;
    ncol  = col;
    case (dir)
      DIR_DOWN: begin
        valid = (32'(row) + 32'd1) < 32'(GRID_SIDE);
        nrow  = row + RCW'(1);
      end
      DIR_RIGHT: begin
        valid = (32'(col) + 32'd1) < 32'(GRID_SIDE);
        ncol  = col + RCW'(1);
      end
      DIR_UP: begin
        valid = (row != '0);
        nrow  = row - RCW'(1);
      end
      DIR_LEFT: begin
        valid = (col != '0);
        ncol  = col - RCW'(1);
      end
      default: begin
        valid = 1'b0;
      end
    endcase
    nidx = CW'(32'(nrow) * 32'(GRID_SIDE) + 32'(ncol));
  end

endmodule

/* src/gmsp_ctrl.sv */
module gmsp_ctrl
  import gmsp_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [COORD_W-1:0] in_cell_col,
  input  logic [COORD_W-1:0] in_cell_row,
  input  logic               in_wall,
  input  logic [COORD_W-1:0] in_start_col,
  input  logic [COORD_W-1:0] in_start_row,
  input  logic [COORD_W-1:0] in_goal_col,
  input  logic [COORD_W-1:0] in_goal_row,
  output logic               res_valid,
  input  logic               res_ready,
  output gmsp_res_t          res
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int RCW   = $clog2(GRID_SIDE);
  localparam int CW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_SCLR, S_SINIT, S_POP, S_POPW, S_CURD,
    S_PROBE, S_PCHK, S_BINIT, S_BPROBE, S_BCHK, S_RESP
  } state_t;

  function automatic logic [CW-1:0] idx_of(input logic [RCW-1:0] r,
                                           input logic [RCW-1:0] c);
    return CW'(32'(r) * 32'(GRID_SIDE) + 32'(c));
  endfunction

  function automatic logic on_grid(input logic [COORD_W-1:0] v);
    return 32'(v) < 32'(GRID_SIDE);
  endfunction

  function automatic logic [RCW-1:0] to_rc(input logic [COORD_W-1:0] v);
    return RCW'(32'(v));
  endfunction

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  logic [CW:0]       head_r;
  logic [CW:0]       tail_r;
  logic [RCW-1:0]    cur_row_r, cur_col_r;
  logic [RCW-1:0]    n_row_r, n_col_r;
  logic [CW-1:0]     n_idx_r;
  logic [DW-1:0]     cur_dist_r;
  logic [DW-1:0]     want_r;
  logic [DW-1:0]     glen_r;
  dir_t              dir_r;
  logic [COORD_W-1:0] sc_r, sr_r, gc_r, gr_r;
  logic              found_r;
  logic [LEN_W-1:0]  len_r;
  cell_state_t       cst_r;

  // shared neighbour unit
  logic              nb_valid;
  logic [RCW-1:0]    nb_row, nb_col;
  logic [CW-1:0]     nb_idx;

  gmsp_nbr #(.GRID_SIDE(GRID_SIDE)) u_nbr (
    .row   (cur_row_r),
    .col   (cur_col_r),
    .dir   (dir_r),
    .valid (nb_valid),
    .nrow  (nb_row),
    .ncol  (nb_col),
    .nidx  (nb_idx)
  );

  // stores
  logic              wall_we, wall_wd, wall_rd;
  logic [CW-1:0]     wall_wa, wall_ra;
  logic              mark_we, mark_wd, mark_rd;
  logic [CW-1:0]     mark_wa, mark_ra;
  logic              dist_we;
  logic [DW-1:0]     dist_wd, dist_rd;
  logic [CW-1:0]     dist_wa, dist_ra;
  logic              q_we;
  logic [2*RCW-1:0]  q_wd, q_rd;
  logic [CW-1:0]     q_wa, q_ra;

  gmsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
    .clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
    .raddr(wall_ra), .rdata(wall_rd)
  );

  gmsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(mark_ra), .rdata(mark_rd)
  );

  gmsp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
    .raddr(dist_ra), .rdata(dist_rd)
  );

  gmsp_ram #(.WIDTH(2*RCW), .DEPTH(CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rd)
  );

  logic              in_xfer;
  logic              in_inside;
  logic [CW-1:0]     in_idx;
  logic              solve_ok;
  logic [RCW-1:0]    s_row, s_col, g_row, g_col;
  logic [RCW-1:0]    q_row, q_col;
  logic              pchk_free;
  logic              bchk_hit;
  logic              at_goal;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign in_inside = on_grid(in_cell_col) && on_grid(in_cell_row);
  assign in_idx    = idx_of(to_rc(in_cell_row), to_rc(in_cell_col));
  assign solve_ok  = on_grid(sc_r) && on_grid(sr_r) && on_grid(gc_r) && on_grid(gr_r);
  assign s_row     = to_rc(sr_r);
  assign s_col     = to_rc(sc_r);
  assign g_row     = to_rc(gr_r);
  assign g_col     = to_rc(gc_r);
  assign q_row     = q_rd[2*RCW-1:RCW];
  assign q_col     = q_rd[RCW-1:0];
  assign pchk_free = !wall_rd && (dist_rd == '0);
  assign bchk_hit  = (dist_rd == want_r - DW'(1));
  assign at_goal   = (n_row_r == g_row) && (n_col_r == g_col);

  assign res_valid       = (state_r == S_RESP);
  assign res.found       = found_r;
  assign res.path_length = len_r;
  assign res.cell_state  = cst_r;

  always_comb begin
    wall_we = 1'b0;
    wall_wa = cnt_r;
    wall_wd = 1'b0;
    wall_ra = (state_r == S_IDLE) ? in_idx : nb_idx;
    mark_we = 1'b0;
    mark_wa = cnt_r;
    mark_wd = 1'b0;
    mark_ra = in_idx;
    dist_we = 1'b0;
    dist_wa = cnt_r;
    dist_wd = '0;
    dist_ra = (state_r == S_POPW) ? idx_of(q_row, q_col) : nb_idx;
    q_we    = 1'b0;
    q_wa    = tail_r[CW-1:0];
    q_wd    = {n_row_r, n_col_r};
    q_ra    = head_r[CW-1:0];
    case (state_r)
      S_CLR: begin
        wall_we = 1'b1;
        mark_we = 1'b1;
      end
      S_IDLE: begin
        if (in_xfer && (cmd_t'(in_cmd) == CMD_WRITE) && in_inside) begin
          wall_we = 1'b1;
          wall_wa = in_idx;
          wall_wd = in_wall;
        end
      end
      S_SCLR: begin
        mark_we = 1'b1;
        dist_we = 1'b1;
      end
      S_SINIT: begin
        if (solve_ok) begin
          dist_we = 1'b1;
          dist_wa = idx_of(s_row, s_col);
          dist_wd = DW'(1);
          q_we    = 1'b1;
          q_wa    = '0;
          q_wd    = {s_row, s_col};
        end
      end
      S_PCHK: begin
        if (pchk_free) begin
          dist_we = 1'b1;
          dist_wa = n_idx_r;
          dist_wd = cur_dist_r + DW'(1);
          q_we    = (32'(tail_r) < 32'(CELLS));
        end
      end
      S_BINIT: begin
        mark_we = 1'b1;
        mark_wa = idx_of(g_row, g_col);
        mark_wd = 1'b1;
      end
      S_BCHK: begin
        if (bchk_hit) begin
          mark_we = 1'b1;
          mark_wa = n_idx_r;
          mark_wd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      dir_r   <= DIR_DOWN;
      found_r <= 1'b0;
      len_r   <= '0;
      cst_r   <= CS_OPEN;
    end else begin
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            cst_r <= CS_OPEN;
            sc_r  <= in_start_col;
            sr_r  <= in_start_row;
            gc_r  <= in_goal_col;
            gr_r  <= in_goal_row;
            case (cmd_t'(in_cmd))
              CMD_SOLVE: begin
                found_r <= 1'b0;
                len_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_SCLR;
              end
              CMD_READ: begin
                if (in_inside) begin
                  state_r <= S_RD;
                end else begin
                  cst_r   <= CS_WALL;
                  state_r <= S_RESP;
                end
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_RD: begin
          cst_r   <= mark_rd ? CS_PATH : (wall_rd ? CS_WALL : CS_OPEN);
          state_r <= S_RESP;
        end
        S_SCLR: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(CELLS - 1)) begin
            state_r <= S_SINIT;
          end
        end
        S_SINIT: begin
          if (!solve_ok) begin
            state_r <= S_RESP;
          end else if ((s_row == g_row) && (s_col == g_col)) begin
            glen_r  <= DW'(1);
            state_r <= S_BINIT;
          end else begin
            head_r  <= '0;
            tail_r  <= (CW+1)'(1);
            state_r <= S_POP;
          end
        end
        S_POP: begin
          if (head_r < tail_r) begin
            head_r  <= head_r + (CW+1)'(1);
            state_r <= S_POPW;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_POPW: begin
          cur_row_r <= q_row;
          cur_col_r <= q_col;
          state_r   <= S_CURD;
        end
        S_CURD: begin
          cur_dist_r <= dist_rd;
          dir_r      <= DIR_DOWN;
          state_r    <= S_PROBE;
        end
        S_PROBE: begin
          if (nb_valid) begin
            n_row_r <= nb_row;
            n_col_r <= nb_col;
            n_idx_r <= nb_idx;
            state_r <= S_PCHK;
          end else if (dir_r == DIR_LEFT) begin
            state_r <= S_POP;
          end else begin
            dir_r <= dir_t'(dir_r + 2'd1);
          end
        end
        S_PCHK: begin
          if (pchk_free && (32'(tail_r) < 32'(CELLS))) begin
            tail_r <= tail_r + (CW+1)'(1);
          end
          if (pchk_free && at_goal) begin
            glen_r  <= cur_dist_r + DW'(1);
            state_r <= S_BINIT;
          end else if (dir_r == DIR_LEFT) begin
            state_r <= S_POP;
          end else begin
            dir_r   <= dir_t'(dir_r + 2'd1);
            state_r <= S_PROBE;
          end
        end
        S_BINIT: begin
          cur_row_r <= g_row;
          cur_col_r <= g_col;
          want_r    <= glen_r;
          dir_r     <= DIR_DOWN;
          found_r   <= 1'b1;
          len_r     <= (32'(glen_r) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(glen_r);
          state_r   <= (glen_r == DW'(1)) ? S_RESP : S_BPROBE;
        end
        S_BPROBE: begin
          if (nb_valid) begin
            n_row_r <= nb_row;
            n_col_r <= nb_col;
            n_idx_r <= nb_idx;
            state_r <= S_BCHK;
          end else if (dir_r == DIR_LEFT) begin
            state_r <= S_RESP;
          end else begin
            dir_r <= dir_t'(dir_r + 2'd1);
          end
        end
        S_BCHK: begin
          if (bchk_hit) begin
            cur_row_r <= n_row_r;
            cur_col_r <= n_col_r;
            want_r    <= want_r - DW'(1);
            dir_r     <= DIR_DOWN;
            state_r   <= (want_r == DW'(2)) ? S_RESP : S_BPROBE;
          end else if (dir_r == DIR_LEFT) begin
            state_r <= S_RESP;
          end else begin
            dir_r   <= dir_t'(dir_r + 2'd1);
            state_r <= S_BPROBE;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/grid_maze_shortest_path.sv */
// Lee maze router over a GRID_SIDE x GRID_SIDE cell grid (16x16 by default).
// Input stream: in_tuser carries the command (write wall bit, solve, read
// cell state); in_tdata carries cell, wall and start/goal coordinates.
// Every command yields exactly one transfer on the output stream with the
// found flag and path length of the last solve, plus the cell state for a
// read (0 open, 1 wall, 2 on path; 0 for other commands).
// After reset the block sweeps the wall and path-mark stores to open,
// one cell per cycle; in_tready stays low until the sweep is done.
// One command at a time, through a single sequencer sharing one neighbour
// address unit and stores with one write port and one registered read port.
// in_tready returns once the result has moved into the output register,
// so a stalled receiver holds one result and blocks only the next one.
module grid_maze_shortest_path
  import gmsp_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cell_col[3:0] cell_row[7:4] wall[8] start_col[12:9] start_row[16:13]
  // goal_col[20:17] goal_row[24:21], zero above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // found[0] path_length[9:1] cell_state[11:10], zero above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic      res_valid, res_ready;
  gmsp_res_t res;
  logic      out_valid_r;
  gmsp_res_t out_res_r;

  gmsp_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_cmd       (in_tuser[1:0]),
    .in_cell_col  (in_tdata[3:0]),
    .in_cell_row  (in_tdata[7:4]),
    .in_wall      (in_tdata[8]),
    .in_start_col (in_tdata[12:9]),
    .in_start_row (in_tdata[16:13]),
    .in_goal_col  (in_tdata[20:17]),
    .in_goal_row  (in_tdata[24:21]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.cell_state, out_res_r.path_length, out_res_r.found};

endmodule

/* src/gmsp_chk.sv */
module gmsp_chk
  import gmsp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // one command in flight: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:10] != 2'd3)
    else $error("bad cell state code");

  a_len_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[9:1] != '0)))
    else $error("found flag and path length disagree");

endmodule

bind grid_maze_shortest_path gmsp_chk u_gmsp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
